### rtl/core/wtsp_pkg.sv
// Shared types and constants for the world-to-screen projection block.
`timescale 1ns / 1ps

package wtsp_pkg;

   // Default fraction bits of the fixed-point coordinates and coefficients.
   localparam int FRAC_BITS_DEF = 16;

   // Integer bits of the normalized device coordinate after saturation.
   localparam int NDC_INT_BITS = 17;

   // Width of the viewport size registers.
   localparam int DIM_W = 14;

   // Width of the register index on the configuration port.
   localparam int CSR_IDX_W = 4;

   // Width of the configuration write data.
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW0_C01 = 4'd0,
      REG_ROW0_C23 = 4'd1,
      REG_ROW1_C01 = 4'd2,
      REG_ROW1_C23 = 4'd3,
      REG_ROW2_C01 = 4'd4,
      REG_ROW2_C23 = 4'd5,
      REG_WIDTH    = 4'd6,
      REG_HEIGHT   = 4'd7
   } csr_reg_type;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd1080;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               visible;
      logic               behind;
   } rsp_type;

   // Control flags that travel beside the two divider lanes.
   typedef struct packed {
      logic valid;
      logic behind;
      logic neg_x;
      logic zero_x;
      logic sat_x;
      logic neg_y;
      logic zero_y;
      logic sat_y;
   } div_tag_type;

endpackage

### rtl/core/wtsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
`timescale 1ns / 1ps

module wtsp_div #(
   parameter int MAG_W     = 50,
   parameter int INT_BITS  = wtsp_pkg::NDC_INT_BITS,
   parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  wtsp_pkg::div_tag_type             in_tag,
   input  logic [MAG_W-1:0]                  in_num_x,
   input  logic [MAG_W-1:0]                  in_num_y,
   input  logic [MAG_W-1:0]                  in_den,
   output wtsp_pkg::div_tag_type             out_tag,
   output logic [INT_BITS+FRAC_BITS-1:0]     out_quo_x,
   output logic [INT_BITS+FRAC_BITS-1:0]     out_quo_y
);

   localparam int QW = INT_BITS + FRAC_BITS;

   wtsp_pkg::div_tag_type tag_ff    [QW+1];
   logic [MAG_W-1:0]      den_ff    [QW+1];
   logic [MAG_W-1:0]      rem_x_ff  [QW+1];
   logic [MAG_W-1:0]      rem_y_ff  [QW+1];
   logic [QW-1:0]         bits_x_ff [QW+1];
   logic [QW-1:0]         bits_y_ff [QW+1];
   logic [QW-1:0]         quo_x_ff  [QW+1];
   logic [QW-1:0]         quo_y_ff  [QW+1];

   // The upper numerator bits seed the remainder; the rest shift in one per stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (advance) begin
         tag_ff[0] <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0]    <= in_den;
         rem_x_ff[0]  <= in_num_x >> INT_BITS;
         rem_y_ff[0]  <= in_num_y >> INT_BITS;
         bits_x_ff[0] <= {in_num_x[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
         bits_y_ff[0] <= {in_num_y[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
         quo_x_ff[0]  <= '0;
         quo_y_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [MAG_W:0]   trial_x;
      logic [MAG_W:0]   trial_y;
      logic [MAG_W:0]   diff_x;
      logic [MAG_W:0]   diff_y;
      logic             ge_x;
      logic             ge_y;
      logic [MAG_W-1:0] rem_x_in;
      logic [MAG_W-1:0] rem_y_in;

      assign trial_x  = {rem_x_ff[k], bits_x_ff[k][QW-1]};
      assign trial_y  = {rem_y_ff[k], bits_y_ff[k][QW-1]};
      assign diff_x   = trial_x - {1'b0, den_ff[k]};
      assign diff_y   = trial_y - {1'b0, den_ff[k]};
      assign ge_x     = trial_x >= {1'b0, den_ff[k]};
      assign ge_y     = trial_y >= {1'b0, den_ff[k]};
      assign rem_x_in = ge_x ? diff_x[MAG_W-1:0] : trial_x[MAG_W-1:0];
      assign rem_y_in = ge_y ? diff_y[MAG_W-1:0] : trial_y[MAG_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else if (advance) begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k+1]    <= den_ff[k];
            rem_x_ff[k+1]  <= rem_x_in;
            rem_y_ff[k+1]  <= rem_y_in;
            bits_x_ff[k+1] <= {bits_x_ff[k][QW-2:0], 1'b0};
            bits_y_ff[k+1] <= {bits_y_ff[k][QW-2:0], 1'b0};
            quo_x_ff[k+1]  <= {quo_x_ff[k][QW-2:0], ge_x};
            quo_y_ff[k+1]  <= {quo_y_ff[k][QW-2:0], ge_y};
         end
      end
   end

   assign out_tag   = tag_ff[QW];
   assign out_quo_x = quo_x_ff[QW];
   assign out_quo_y = quo_y_ff[QW];

`ifndef SYNTH
   // A quotient that is used must leave a remainder below the divisor.
   a_rem_x: assert property (@(posedge clock) disable iff (reset)
      tag_ff[QW].valid && !tag_ff[QW].sat_x && !tag_ff[QW].zero_x
         |-> rem_x_ff[QW] < den_ff[QW])
      else $error("x lane remainder not below divisor");

   a_rem_y: assert property (@(posedge clock) disable iff (reset)
      tag_ff[QW].valid && !tag_ff[QW].sat_y && !tag_ff[QW].zero_y
         |-> rem_y_ff[QW] < den_ff[QW])
      else $error("y lane remainder not below divisor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tag_ff[QW]) && $stable(quo_x_ff[QW]))
      else $error("divider output moved during a stall");
`endif

endmodule

### rtl/core/world_to_screen_projection.sv
// Top level of the world-to-screen projection pipeline.
`timescale 1ns / 1ps

//  Channel   Ports                               Beat carries
//  ------    ----------------------------------  -----------------------------------
//  request   req_valid, req_ready, req_data      one world point (x, y, z)
//  response  rsp_valid, rsp_ready, rsp_data      pixel x, y, visible and behind flags
//  config    csr_valid, csr_ready, csr_index,    one register write (index, 64-bit data)
//            csr_data
//
// One point enters per clock while the output is not stalled; the divider resolves one
// quotient bit per stage over NDC_INT_BITS + FRAC_BITS stages.
// Reset is synchronous, clears every valid bit and the matrix registers and loads the default viewport size.
// The whole pipeline advances together whenever the output register is empty or its
// beat is being taken, so a stall freezes every stage and nothing is lost or repeated.
// Configuration writes are taken in any cycle.

module world_to_screen_projection #(
   parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  wtsp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output wtsp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wtsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wtsp_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int DIM_W  = wtsp_pkg::DIM_W;
   localparam int NINT   = wtsp_pkg::NDC_INT_BITS;
   // Clip values: floored products keep 64 - FRAC_BITS bits, plus two bits of sum growth.
   localparam int CLIP_W = 66 - FRAC_BITS;
   localparam int QW     = NINT + FRAC_BITS;
   localparam int NDC_W  = QW + 2;
   localparam int MUL_W  = NDC_W + DIM_W + 1;
   localparam int PIX_W  = MUL_W + 1;
   localparam int TRN_W  = PIX_W - FRAC_BITS - 1;
   // 0.001 in fixed point, rounded to nearest.
   localparam int THR    = ((1 << FRAC_BITS) + 500) / 1000;

   localparam logic signed [CLIP_W-1:0] THR_S   = CLIP_W'(THR);
   localparam logic        [NDC_W-1:0]  NDC_LIM = NDC_W'(1) << QW;
   localparam logic signed [PIX_W-1:0]  ONE_P   = PIX_W'(1) << FRAC_BITS;
   localparam logic signed [PIX_W-1:0]  BIAS_P  = (PIX_W'(1) << (FRAC_BITS + 1)) - PIX_W'(1);
   localparam logic signed [TRN_W-1:0]  MAX16   = TRN_W'(32767);
   localparam logic signed [TRN_W-1:0]  MIN16   = TRN_W'(-32768);

   // ------------------------------------------------------------------------
   // Configuration registers. The port never pushes back.
   // ------------------------------------------------------------------------
   logic [63:0]      mat_ff [6];
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            mat_ff[i] <= '0;
         end
         width_ff  <= wtsp_pkg::WIDTH_RESET;
         height_ff <= wtsp_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            wtsp_pkg::REG_ROW0_C01: mat_ff[0] <= csr_data;
            wtsp_pkg::REG_ROW0_C23: mat_ff[1] <= csr_data;
            wtsp_pkg::REG_ROW1_C01: mat_ff[2] <= csr_data;
            wtsp_pkg::REG_ROW1_C23: mat_ff[3] <= csr_data;
            wtsp_pkg::REG_ROW2_C01: mat_ff[4] <= csr_data;
            wtsp_pkg::REG_ROW2_C23: mat_ff[5] <= csr_data;
            wtsp_pkg::REG_WIDTH:    width_ff  <= csr_data[DIM_W-1:0];
            wtsp_pkg::REG_HEIGHT:   height_ff <= csr_data[DIM_W-1:0];
            default: begin
               // Indexes past the register list are dropped.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control. Every stage moves when the output register can take
   // a new beat, so the valid bits and the data shift together.
   // ------------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ------------------------------------------------------------------------
   // Stage A: the nine coefficient by coordinate products, one multiplier each.
   // ------------------------------------------------------------------------
   logic signed [31:0] pt [3];
   logic               va_ff;
   logic signed [63:0] prod_ff  [3][3];
   logic signed [31:0] trans_ff [3];

   assign pt[0] = req_data.world_x;
   assign pt[1] = req_data.world_y;
   assign pt[2] = req_data.world_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= req_valid;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         logic signed [31:0] coef;
         logic signed [63:0] prod_in;

         assign coef    = $signed(mat_ff[r*2 + c/2][(c%2)*32 +: 32]);
         assign prod_in = coef * pt[c];

         always_ff @(posedge clock) begin
            if (advance) begin
               prod_ff[r][c] <= prod_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            trans_ff[r] <= $signed(mat_ff[r*2 + 1][63:32]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: floor each product to the working fraction and sum the row.
   // ------------------------------------------------------------------------
   logic                     vb_ff;
   logic signed [CLIP_W-1:0] clip_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= va_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_sum
      logic signed [CLIP_W-1:0] term [3];
      logic signed [CLIP_W-1:0] clip_in;

      for (genvar c = 0; c < 3; c++) begin : g_term
         // Dropping the low bits of a two's-complement word is a floor.
         assign term[c] = $signed({{2{prod_ff[r][c][63]}}, prod_ff[r][c][63:FRAC_BITS]});
      end

      assign clip_in = term[0] + term[1] + term[2] + CLIP_W'(trans_ff[r]);

      always_ff @(posedge clock) begin
         if (advance) begin
            clip_ff[r] <= clip_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage C: behind test, magnitudes and quotient signs.
   // ------------------------------------------------------------------------
   logic              behind_c_in;
   logic              dneg_c_in;
   logic [CLIP_W-1:0] ax_c_in;
   logic [CLIP_W-1:0] ay_c_in;
   logic [CLIP_W-1:0] ad_c_in;
   logic              vc_ff;
   logic              behind_c_ff;
   logic              neg_x_c_ff;
   logic              neg_y_c_ff;
   logic [CLIP_W-1:0] ax_c_ff;
   logic [CLIP_W-1:0] ay_c_ff;
   logic [CLIP_W-1:0] ad_c_ff;

   assign behind_c_in = clip_ff[2] < THR_S;
   // The divisor is -w for a point behind the camera, w otherwise.
   assign dneg_c_in   = behind_c_in ? (clip_ff[2] > $signed(CLIP_W'(0))) : clip_ff[2][CLIP_W-1];
   assign ax_c_in     = clip_ff[0][CLIP_W-1] ? CLIP_W'(-clip_ff[0]) : CLIP_W'(clip_ff[0]);
   assign ay_c_in     = clip_ff[1][CLIP_W-1] ? CLIP_W'(-clip_ff[1]) : CLIP_W'(clip_ff[1]);
   assign ad_c_in     = clip_ff[2][CLIP_W-1] ? CLIP_W'(-clip_ff[2]) : CLIP_W'(clip_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (advance) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         behind_c_ff <= behind_c_in;
         neg_x_c_ff  <= clip_ff[0][CLIP_W-1] ^ dneg_c_in;
         neg_y_c_ff  <= clip_ff[1][CLIP_W-1] ^ dneg_c_in;
         ax_c_ff     <= ax_c_in;
         ay_c_ff     <= ay_c_in;
         ad_c_ff     <= ad_c_in;
      end
   end

   // ------------------------------------------------------------------------
   // Divider entry: a quotient of 2^NDC_INT_BITS or more saturates, which also
   // covers a zero divisor; a zero numerator gives zero.
   // ------------------------------------------------------------------------
   wtsp_pkg::div_tag_type div_tag_in;
   wtsp_pkg::div_tag_type div_tag_out;
   logic [QW-1:0]         quo_x;
   logic [QW-1:0]         quo_y;

   always_comb begin
      div_tag_in        = '0;
      div_tag_in.valid  = vc_ff;
      div_tag_in.behind = behind_c_ff;
      div_tag_in.neg_x  = neg_x_c_ff;
      div_tag_in.neg_y  = neg_y_c_ff;
      div_tag_in.zero_x = ax_c_ff == '0;
      div_tag_in.zero_y = ay_c_ff == '0;
      div_tag_in.sat_x  = {{NINT{1'b0}}, ax_c_ff} >= {ad_c_ff, {NINT{1'b0}}};
      div_tag_in.sat_y  = {{NINT{1'b0}}, ay_c_ff} >= {ad_c_ff, {NINT{1'b0}}};
   end

   wtsp_div #(
      .MAG_W     (CLIP_W),
      .INT_BITS  (NINT),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_tag    (div_tag_in),
      .in_num_x  (ax_c_ff),
      .in_num_y  (ay_c_ff),
      .in_den    (ad_c_ff),
      .out_tag   (div_tag_out),
      .out_quo_x (quo_x),
      .out_quo_y (quo_y)
   );

   // ------------------------------------------------------------------------
   // Stage E: signed normalized coordinates.
   // ------------------------------------------------------------------------
   logic [NDC_W-1:0]        mag_x;
   logic [NDC_W-1:0]        mag_y;
   logic                    ve_ff;
   logic                    be_ff;
   logic signed [NDC_W-1:0] nx_ff;
   logic signed [NDC_W-1:0] ny_ff;

   always_comb begin
      priority if (div_tag_out.zero_x) begin
         mag_x = '0;
      end else if (div_tag_out.sat_x) begin
         mag_x = NDC_LIM;
      end else begin
         mag_x = {2'b00, quo_x};
      end
      priority if (div_tag_out.zero_y) begin
         mag_y = '0;
      end else if (div_tag_out.sat_y) begin
         mag_y = NDC_LIM;
      end else begin
         mag_y = {2'b00, quo_y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (advance) begin
         ve_ff <= div_tag_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         be_ff <= div_tag_out.behind;
         nx_ff <= div_tag_out.neg_x ? -$signed(mag_x) : $signed(mag_x);
         ny_ff <= div_tag_out.neg_y ? -$signed(mag_y) : $signed(mag_y);
      end
   end

   // ------------------------------------------------------------------------
   // Stage F: scale by the viewport size.
   // ------------------------------------------------------------------------
   logic                    vf_ff;
   logic                    bf_ff;
   logic signed [MUL_W-1:0] mx_ff;
   logic signed [MUL_W-1:0] my_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (advance) begin
         vf_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bf_ff <= be_ff;
         mx_ff <= nx_ff * $signed({1'b0, width_ff});
         my_ff <= ny_ff * $signed({1'b0, height_ff});
      end
   end

   // ------------------------------------------------------------------------
   // Stage G: exact pixel values with one extra fraction bit.
   // ------------------------------------------------------------------------
   logic signed [PIX_W-1:0] half_x;
   logic signed [PIX_W-1:0] half_y;
   logic                    vg_ff;
   logic                    bg_ff;
   logic signed [PIX_W-1:0] sxv_ff;
   logic signed [PIX_W-1:0] syv_ff;

   assign half_x = $signed(PIX_W'({1'b0, width_ff[DIM_W-1:1]}) << (FRAC_BITS + 1));
   assign half_y = $signed(PIX_W'({1'b0, height_ff[DIM_W-1:1]}) << (FRAC_BITS + 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else if (advance) begin
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bg_ff  <= bf_ff;
         sxv_ff <= half_x + PIX_W'(mx_ff) + ONE_P;
         syv_ff <= half_y - PIX_W'(my_ff) - ONE_P;
      end
   end

   // ------------------------------------------------------------------------
   // Stage H: visibility, truncation toward zero and 16-bit saturation into
   // the output register.
   // ------------------------------------------------------------------------
   logic signed [PIX_W-1:0] lim_x;
   logic signed [PIX_W-1:0] lim_y;
   logic signed [PIX_W-1:0] bx;
   logic signed [PIX_W-1:0] by;
   logic signed [TRN_W-1:0] tx;
   logic signed [TRN_W-1:0] ty;
   wtsp_pkg::rsp_type       rsp_in;
   wtsp_pkg::rsp_type       rsp_data_ff;

   assign lim_x = $signed(PIX_W'(width_ff) << (FRAC_BITS + 1));
   assign lim_y = $signed(PIX_W'(height_ff) << (FRAC_BITS + 1));
   // Negative values get a bias so that the shift rounds toward zero.
   assign bx    = sxv_ff + (sxv_ff[PIX_W-1] ? BIAS_P : '0);
   assign by    = syv_ff + (syv_ff[PIX_W-1] ? BIAS_P : '0);
   assign tx    = $signed(bx[PIX_W-1:FRAC_BITS+1]);
   assign ty    = $signed(by[PIX_W-1:FRAC_BITS+1]);

   always_comb begin
      rsp_in         = '0;
      rsp_in.behind  = bg_ff;
      rsp_in.visible = !bg_ff && !sxv_ff[PIX_W-1] && (sxv_ff <= lim_x)
                       && !syv_ff[PIX_W-1] && (syv_ff <= lim_y);
      priority if (tx > MAX16) begin
         rsp_in.screen_x = 16'sd32767;
      end else if (tx < MIN16) begin
         rsp_in.screen_x = -16'sd32768;
      end else begin
         rsp_in.screen_x = tx[15:0];
      end
      priority if (ty > MAX16) begin
         rsp_in.screen_y = 16'sd32767;
      end else if (ty < MIN16) begin
         rsp_in.screen_y = -16'sd32768;
      end else begin
         rsp_in.screen_y = ty[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A point behind the camera is never reported as visible.
   a_vis_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.visible |-> !rsp_data.behind)
      else $error("visible point flagged behind");

   // A visible pixel lies inside the viewport, so it is never negative.
   a_vis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.visible |-> !rsp_data.screen_x[15] && !rsp_data.screen_y[15])
      else $error("visible point outside the viewport");

   // A width write lands in the width register.
   a_width_wr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == wtsp_pkg::REG_WIDTH)
         |=> width_ff == $past(csr_data[DIM_W-1:0]))
      else $error("width register write lost");
`endif

endmodule

### tb/sv/wtsp_checker.sv
// Scoreboard for the world-to-screen projection block: predicts each pixel beat and compares.
`timescale 1ns / 1ps

module wtsp_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  wtsp_pkg::req_type                     req_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  wtsp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [wtsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wtsp_pkg::CSR_DATA_W-1:0]       csr_data,
   output int                                    errors,
   output int                                    pending
);

   localparam int     FRAC = wtsp_pkg::FRAC_BITS_DEF;
   localparam int     NINT = wtsp_pkg::NDC_INT_BITS;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint W_THRESH = (ONE + 500) / 1000;
   localparam longint NDC_LIMIT = longint'(1) << (NINT + FRAC);

   logic [63:0]                mat_words_ff[6];
   logic [wtsp_pkg::DIM_W-1:0] view_w_ff;
   logic [wtsp_pkg::DIM_W-1:0] view_h_ff;
   wtsp_pkg::rsp_type          expected_pixels[$];

   function automatic longint coef_of(int row, int col);
      logic [63:0] word;
      word = mat_words_ff[row * 2 + col / 2];
      if (col % 2 != 0)
         return longint'($signed(word[63:32]));
      return longint'($signed(word[31:0]));
   endfunction

   // Each product is floored back to the coordinate format before summing.
   function automatic longint row_sum(int row, longint px, longint py, longint pz);
      return coef_of(row, 3) + ((coef_of(row, 0) * px) >>> FRAC)
             + ((coef_of(row, 1) * py) >>> FRAC) + ((coef_of(row, 2) * pz) >>> FRAC);
   endfunction

   // Quotient truncated toward zero; a zero divisor or a huge quotient saturates.
   function automatic longint ndc_quot(longint num, longint den);
      longint unsigned an, ad, q, r;
      bit              neg;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      if (an == 0)
         return 0;
      if (ad == 0) begin
         q = NDC_LIMIT;
         neg = num < 0;
      end else begin
         q = an / ad;
         if (q >= (longint'(1) << NINT)) begin
            q = NDC_LIMIT;
         end else begin
            r = an % ad;
            for (int i = 0; i < FRAC; i++) begin
               r = r << 1;
               q = q << 1;
               if (r >= ad) begin
                  r = r - ad;
                  q = q | 1;
               end
            end
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic wtsp_pkg::rsp_type project_point(wtsp_pkg::req_type p);
      wtsp_pkg::rsp_type res;
      longint            cx, cy, w, d, nx, ny, sxv, syv, wd, ht;
      logic              is_behind;
      wd = longint'(view_w_ff);
      ht = longint'(view_h_ff);
      cx = row_sum(0, p.world_x, p.world_y, p.world_z);
      cy = row_sum(1, p.world_x, p.world_y, p.world_z);
      w  = row_sum(2, p.world_x, p.world_y, p.world_z);
      is_behind = w < W_THRESH;
      d = is_behind ? -w : w;
      nx = ndc_quot(cx, d);
      ny = ndc_quot(cy, d);
      // Pixel values carry one extra fraction bit so the half-pixel offset is exact.
      sxv = (wd >>> 1) * (ONE * 2) + nx * wd + ONE;
      syv = (ht >>> 1) * (ONE * 2) - (ny * ht + ONE);
      res.screen_x = clamp16(sxv / (ONE * 2));
      res.screen_y = clamp16(syv / (ONE * 2));
      res.behind   = is_behind;
      res.visible  = !is_behind && sxv >= 0 && sxv <= wd * ONE * 2 &&
                     syv >= 0 && syv <= ht * ONE * 2;
      return res;
   endfunction

   always @(posedge clock) begin
      wtsp_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < 6; i++)
            mat_words_ff[i] <= '0;
         view_w_ff <= wtsp_pkg::WIDTH_RESET;
         view_h_ff <= wtsp_pkg::HEIGHT_RESET;
         expected_pixels.delete();
         errors = 0;
         pending = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: unexpected pixel beat %p", rsp_data);
            end else begin
               want = expected_pixels.pop_front();
               if (want.screen_x !== rsp_data.screen_x ||
                   want.screen_y !== rsp_data.screen_y ||
                   want.visible !== rsp_data.visible || want.behind !== rsp_data.behind) begin
                  errors++;
                  if (errors <= 10)
                     $display({"ERROR: pixel mismatch expected x=%0d y=%0d vis=%0b beh=%0b,",
                               " got x=%0d y=%0d vis=%0b beh=%0b"},
                              want.screen_x, want.screen_y, want.visible, want.behind,
                              rsp_data.screen_x, rsp_data.screen_y, rsp_data.visible,
                              rsp_data.behind);
               end
            end
         end
         if (req_valid && req_ready)
            expected_pixels.push_back(project_point(req_data));
         pending = expected_pixels.size();
         // Register writes must come only while the pipeline is idle; this checker does not enforce it.
         if (csr_valid && csr_ready) begin
            if (csr_index < wtsp_pkg::REG_WIDTH)
               mat_words_ff[csr_index[2:0]] <= csr_data;
            else if (csr_index == wtsp_pkg::REG_WIDTH)
               view_w_ff <= csr_data[wtsp_pkg::DIM_W-1:0];
            else if (csr_index == wtsp_pkg::REG_HEIGHT)
               view_h_ff <= csr_data[wtsp_pkg::DIM_W-1:0];
         end
      end
   end

endmodule

### tb/sv/world_to_screen_projection_tb.sv
// Top of the world-to-screen projection testbench: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module world_to_screen_projection_tb;

   // An index past the last register; the block must ignore writes to it.
   localparam logic [wtsp_pkg::CSR_IDX_W-1:0] REG_UNUSED = 4'd11;
   localparam logic [31:0] FIX_ONE = 32'h0001_0000;
   // No accepted beat for this many cycles means the block is hung.
   localparam int WATCHDOG_LIMIT = 3000;
   // The pipeline is 41 stages deep; this pause covers it with margin.
   localparam int DRAIN_CYCLES = 100;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   wtsp_pkg::req_type                     req_data;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   wtsp_pkg::rsp_type                     rsp_data;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [wtsp_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [wtsp_pkg::CSR_DATA_W-1:0]       csr_data;
   int                                    errors;
   int                                    pending;
   int                                    stall_free_cycles_ff;
   bit                                    quiet;

   world_to_screen_projection u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   wtsp_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // The watchdog restarts whenever any channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_free_cycles_ff <= 0;
      end else if (stall_free_cycles_ff >= WATCHDOG_LIMIT) begin
         $display("world_to_screen_projection_tb: done, errors");
         $finish;
      end else begin
         stall_free_cycles_ff <= stall_free_cycles_ff + 1;
      end
   end

   // The receiver alternates between ready stretches and stall bursts.
   // Once the run goes quiet it simply takes every beat.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         if (quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Valid stays up between back-to-back points; it only drops for an idle burst,
   // so it never gets two assignments within one step.
   task automatic send_point(input wtsp_pkg::req_type pt);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pt;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      wtsp_pkg::req_type pt;
      pt.world_x = x;
      pt.world_y = y;
      pt.world_z = z;
      send_point(pt);
   endtask

   task automatic write_reg(input logic [wtsp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Registers change only with the pipeline empty, so wait for the last beat and
   // then give the pipeline its depth to settle.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_matrix(input logic [31:0] m[12]);
      write_reg(wtsp_pkg::REG_ROW0_C01, {m[1], m[0]});
      write_reg(wtsp_pkg::REG_ROW0_C23, {m[3], m[2]});
      write_reg(wtsp_pkg::REG_ROW1_C01, {m[5], m[4]});
      write_reg(wtsp_pkg::REG_ROW1_C23, {m[7], m[6]});
      write_reg(wtsp_pkg::REG_ROW2_C01, {m[9], m[8]});
      write_reg(wtsp_pkg::REG_ROW2_C23, {m[11], m[10]});
   endtask

   function automatic logic [31:0] small_coef();
      return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   // Most points are built to land near or inside the view frustum of a camera that
   // looks down +z; the rest are raw bit patterns and points with w near zero.
   task automatic send_random_point();
      int          pick;
      logic [31:0] z;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         z = $urandom_range(1, 64) * FIX_ONE + $urandom_range(0, 16'hFFFF);
         send_xyz($urandom_range(0, 2 * z) - z + $urandom_range(0, z >> 2),
                  $urandom_range(0, 2 * z) - z - $urandom_range(0, z >> 2), z);
      end else if (pick < 85) begin
         send_xyz($urandom, $urandom, $urandom);
      end else begin
         send_xyz($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                  $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                  $urandom_range(0, 200) - 100);
      end
   endtask

   initial begin
      logic [31:0] m[12];
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = wtsp_pkg::REG_ROW0_C01;
      csr_data  = '0;
      quiet     = 1'b0;
      reset     = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset matrix every w is zero, so every point is behind.
      send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_xyz(FIX_ONE, FIX_ONE, FIX_ONE);
      drain_pipeline();

      // Plain camera: clip x = x, clip y = y, w = z.
      m = '{FIX_ONE, 0, 0, 0, 0, FIX_ONE, 0, 0, 0, 0, FIX_ONE, 0};
      load_matrix(m);
      write_reg(wtsp_pkg::REG_WIDTH, 64'd640);
      write_reg(wtsp_pkg::REG_HEIGHT, 64'd480);
      drain_pipeline();
      send_xyz(0, 0, FIX_ONE);
      send_xyz(FIX_ONE, FIX_ONE, FIX_ONE);
      send_xyz(-FIX_ONE, -FIX_ONE, FIX_ONE);
      send_xyz(FIX_ONE, -FIX_ONE, FIX_ONE);
      // Zero w with positive, negative and zero clip coordinates.
      send_xyz(FIX_ONE, -FIX_ONE, 0);
      send_xyz(-FIX_ONE, FIX_ONE, 0);
      send_xyz(0, 0, 0);
      // Just below and right at the behind threshold.
      send_xyz(32'd5, 32'd5, 32'd65);
      send_xyz(32'd5, 32'd5, 32'd66);
      // Points behind the camera.
      send_xyz(FIX_ONE, FIX_ONE, -FIX_ONE);
      send_xyz(32'h0004_0000, -32'h0002_0000, -32'h0003_0000);
      // Field extremes and huge quotients that saturate the pixel.
      send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'd1000);
      send_xyz(32'h8000_0000, 32'h7FFF_FFFF, FIX_ONE);
      send_xyz(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
      send_xyz(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (300) send_random_point();
      drain_pipeline();

      // Narrow field of view on a one-pixel viewport.
      m = '{2 * FIX_ONE, 0, 0, 0, 0, 2 * FIX_ONE, 0, 0, 0, 0, FIX_ONE, 0};
      load_matrix(m);
      write_reg(wtsp_pkg::REG_WIDTH, 64'd1);
      write_reg(wtsp_pkg::REG_HEIGHT, 64'd1);
      drain_pipeline();
      repeat (300) send_random_point();
      drain_pipeline();

      // Largest legal viewport and a camera with rotation and translation.
      foreach (m[i])
         m[i] = small_coef();
      m[10] = FIX_ONE;
      load_matrix(m);
      write_reg(wtsp_pkg::REG_WIDTH, 64'd8192);
      write_reg(wtsp_pkg::REG_HEIGHT, 64'd8192);
      drain_pipeline();
      repeat (300) send_random_point();
      drain_pipeline();

      // Sizes outside the legal range are used as written; upper data bits are dropped.
      foreach (m[i])
         m[i] = $urandom;
      load_matrix(m);
      write_reg(wtsp_pkg::REG_WIDTH, {$urandom, 18'h0, 14'h3FFF});
      write_reg(wtsp_pkg::REG_HEIGHT, 64'd0);
      drain_pipeline();
      repeat (300) send_random_point();
      drain_pipeline();

      // Extreme coefficients; a write to an unused index must change nothing.
      m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      load_matrix(m);
      write_reg(wtsp_pkg::REG_WIDTH, 64'd1920);
      write_reg(wtsp_pkg::REG_HEIGHT, 64'd1080);
      write_reg(REG_UNUSED, '1);
      drain_pipeline();
      repeat (100) send_random_point();
      drain_pipeline();

      // Back to a sane camera for the final stretch, with no idling on either side.
      m = '{FIX_ONE, 0, 0, 0, 0, FIX_ONE, 0, 0, 0, 0, FIX_ONE, 0};
      load_matrix(m);
      write_reg(REG_UNUSED, 64'h0);
      drain_pipeline();
      quiet = 1'b1;
      repeat (300) send_random_point();
      drain_pipeline();

      if (errors == 0 && pending == 0)
         $display("world_to_screen_projection_tb: done, clean");
      else
         $display("world_to_screen_projection_tb: done, errors");
      $finish;
   end

endmodule

### files.f
rtl/core/wtsp_pkg.sv
rtl/core/wtsp_div.sv
rtl/core/world_to_screen_projection.sv
tb/sv/wtsp_checker.sv
tb/sv/world_to_screen_projection_tb.sv
